// ----- sv/sorted_name_table_top_macros.svh -----
// ---------------------------------------------------------------------------
// sorted_name_table_top_macros.svh
// Assertion macros for the sorted name table checker.
// ---------------------------------------------------------------------------
`ifndef SORTED_NAME_TABLE_TOP_MACROS_SVH
`define SORTED_NAME_TABLE_TOP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SNT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define SNT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks across reset.
`define SNT_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/snt_pkg.sv -----
// ---------------------------------------------------------------------------
// snt_pkg
// Types, codes and helpers for the sorted name table.
// ---------------------------------------------------------------------------
package snt_pkg;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int NAME_BYTES_DEF  = 32;

  localparam int KEY_LEN  = 31;
  localparam int NAME_W   = KEY_LEN * 8;
  localparam int KIND_W   = 2;
  localparam int HANDLE_W = 16;
  localparam int POS_W    = 9;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic                op;
    logic [63:0]         name_a;
    logic [63:0]         name_b;
    logic [63:0]         name_c;
    logic [55:0]         name_d;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle_in;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]   kind_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [POS_W-1:0]    position;
  } result_t;

  // Zero every byte from the first NUL on, and every byte past the used length.
  function automatic logic [NAME_W-1:0] mask_name(input logic [NAME_W-1:0] raw,
                                                  input int unsigned used);
    logic [NAME_W-1:0] key;
    logic              ended;
    logic [7:0]        b;
    key   = '0;
    ended = 1'b0;
    for (int k = 0; k < KEY_LEN; k++) begin
      b = raw[NAME_W-1-8*k -: 8];
      if (k >= used) ended = 1'b1;
      if (!ended) begin
        key[NAME_W-1-8*k -: 8] = b;
        if (b == 8'd0) ended = 1'b1;
      end
    end
    return key;
  endfunction

endpackage

// ----- sv/snt_ram.sv -----
// ---------------------------------------------------------------------------
// snt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module snt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/snt_seq.sv -----
// ---------------------------------------------------------------------------
// snt_seq
// Insert-shift and binary-search sequencer around the entry RAM.
// ---------------------------------------------------------------------------
module snt_seq #(
  parameter int TABLE_DEPTH = 512,
  parameter int NAME_BYTES  = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  snt_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output snt_pkg::result_t res
);
  import snt_pkg::*;

  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int KEY_USED = NAME_BYTES - 1;
  localparam int KEY_W    = KEY_USED * 8;
  localparam int ENT_W    = KEY_W + KIND_W + HANDLE_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_CMP = 3'd1;
  localparam logic [2:0] ST_INS_PUT = 3'd2;
  localparam logic [2:0] ST_LK_RD   = 3'd3;
  localparam logic [2:0] ST_LK_CMP  = 3'd4;
  localparam logic [2:0] ST_FIN     = 3'd5;

  logic [2:0]          state, state_next;
  logic [AW-1:0]       cnt, cnt_next;
  logic [AW-1:0]       pos, pos_next;
  logic [AW-1:0]       lo, lo_next;
  logic [AW-1:0]       hi1, hi1_next;
  logic [AW-1:0]       mid_q, mid_q_next;
  logic [KEY_W-1:0]    key_q;
  logic [KIND_W-1:0]   kind_q;
  logic [HANDLE_W-1:0] handle_q;
  result_t             res_q, res_next;

  logic [NAME_W-1:0]   key_full;
  logic [KEY_W-1:0]    key_in;
  logic                accept;
  logic [AW:0]         mid_sum;
  logic [AW-1:0]       mid;

  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [ENT_W-1:0]    wr_data, rd_data;
  logic [KEY_W-1:0]    rd_key;
  logic [KIND_W-1:0]   rd_kind;
  logic [HANDLE_W-1:0] rd_handle;
  logic                key_lt, key_eq;

  snt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign key_full   = mask_name({item.name_a, item.name_b, item.name_c, item.name_d},
                                KEY_USED);
  assign key_in     = key_full[NAME_W-1 -: KEY_W];
  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign res_valid  = (state == ST_FIN);
  assign res        = res_q;

  assign rd_key    = rd_data[ENT_W-1 -: KEY_W];
  assign rd_kind   = rd_data[HANDLE_W +: KIND_W];
  assign rd_handle = rd_data[HANDLE_W-1:0];
  // Bytes sit most significant first, so byte order equals unsigned order.
  assign key_lt    = (key_q < rd_key);
  assign key_eq    = (key_q == rd_key);

  assign mid_sum = {1'b0, lo} + {1'b0, hi1} - (AW+1)'(1);
  assign mid     = mid_sum[AW:1];

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pos_next   = pos;
    lo_next    = lo;
    hi1_next   = hi1;
    mid_q_next = mid_q;
    res_next   = res_q;
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = pos - AW'(1);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.op == OP_INSERT) begin
            if (cnt >= AW'(TABLE_DEPTH - 1)) begin
              res_next   = '{status: STATUS_FULL, kind_out: '0, handle_out: '0,
                             position: '0};
              state_next = ST_FIN;
            end else begin
              pos_next = cnt;
              if (cnt != '0) begin
                rd_en      = 1'b1;
                rd_addr    = cnt - AW'(1);
                state_next = ST_INS_CMP;
              end else begin
                state_next = ST_INS_PUT;
              end
            end
          end else begin
            lo_next    = '0;
            hi1_next   = cnt;
            state_next = ST_LK_RD;
          end
        end
      end
      ST_INS_CMP: begin
        // Move the larger entry up one slot and prefetch the one below it.
        if (key_lt) begin
          wr_en    = 1'b1;
          wr_addr  = pos;
          wr_data  = rd_data;
          pos_next = pos - AW'(1);
          if (pos != AW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = pos - AW'(2);
          end else begin
            state_next = ST_INS_PUT;
          end
        end else begin
          state_next = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = pos;
        wr_data    = {key_q, kind_q, handle_q};
        cnt_next   = cnt + AW'(1);
        res_next   = '{status: STATUS_OK, kind_out: kind_q, handle_out: handle_q,
                       position: POS_W'(pos)};
        state_next = ST_FIN;
      end
      ST_LK_RD: begin
        if (lo < hi1) begin
          rd_en      = 1'b1;
          rd_addr    = mid;
          mid_q_next = mid;
          state_next = ST_LK_CMP;
        end else begin
          res_next   = '{status: STATUS_NOT_FOUND, kind_out: '0, handle_out: '0,
                         position: '0};
          state_next = ST_FIN;
        end
      end
      ST_LK_CMP: begin
        if (key_eq) begin
          res_next   = '{status: STATUS_OK, kind_out: rd_kind, handle_out: rd_handle,
                         position: POS_W'(mid_q)};
          state_next = ST_FIN;
        end else begin
          if (key_lt) begin
            hi1_next = mid_q;
          end else begin
            lo_next = mid_q + AW'(1);
          end
          state_next = ST_LK_RD;
        end
      end
      ST_FIN: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    lo    <= lo_next;
    hi1   <= hi1_next;
    mid_q <= mid_q_next;
    res_q <= res_next;
    if (accept) begin
      key_q    <= key_in;
      kind_q   <= item.kind;
      handle_q <= item.handle_in;
    end
  end

endmodule

// ----- sv/sorted_name_table_top.sv -----
// ---------------------------------------------------------------------------
// sorted_name_table_top
// Name-sorted entry table with shifting insert and binary-search lookup.
// ---------------------------------------------------------------------------
// One item is worked at a time. A lookup runs one binary-search probe after
// another, each an address out, then a compare on the registered RAM data,
// so a table of n entries takes up to ceil(log2(n+1)) probes; a full table
// holds 511 entries. An insert moves each entry that sorts above the new
// name up one slot (the read of the next lower entry overlaps the write of
// the current one on the two RAM ports), then writes the new entry; no
// closing compare is needed when the new name sorts first. A full-table
// insert answers straight from idle with a table-full status. The entry RAM
// needs no clearing pass: only entries below the entry count are ever read.
// While a result beat waits on the output, the next item is already accepted
// and worked.
// ---------------------------------------------------------------------------
module sorted_name_table_top #(
  parameter int TABLE_DEPTH = snt_pkg::TABLE_DEPTH_DEF,
  parameter int NAME_BYTES  = snt_pkg::NAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  snt_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output snt_pkg::result_t result
);
  import snt_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;

  // Sequencer: owns the entry RAM and the entry count.
  snt_seq #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NAME_BYTES (NAME_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: take a new result when the slot is empty or draining.
  assign res_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res_valid;
    end
  end

  // Hold the payload while the beat is stalled.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      result <= res;
    end
  end

endmodule

// ----- sv/snt_checker.sv -----
// ---------------------------------------------------------------------------
// snt_checker
// Port-level checks on the sorted name table, bound to the top level.
// ---------------------------------------------------------------------------
`include "sorted_name_table_top_macros.svh"

module snt_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input snt_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_ready,
  input snt_pkg::result_t result
);
  import snt_pkg::*;

  `SNT_ASSERT_ALWAYS(a_reset_clears_out, clk, rst, !result_valid, "result valid after reset")

  `SNT_ASSERT_NEXT(a_one_in_flight, clk, rst, item_valid && item_ready, !item_ready,
                   "second item taken while one is in flight")

  `SNT_ASSERT_NOW(a_full_zero_fields, clk, rst,
                  result_valid && (result.status == STATUS_FULL),
                  (result.kind_out == '0) && (result.handle_out == '0) &&
                  (result.position == '0),
                  "table-full result carries nonzero fields")

  `SNT_ASSERT_NEXT(a_out_hold, clk, rst, result_valid && !result_ready,
                   result_valid && $stable(result), "stalled result beat changed")

endmodule

bind sorted_name_table_top snt_checker u_snt_checker (.*);
